// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros, clocked on clk_i and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define CQS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

`define CQS_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`else

`define CQS_ASSERT(lbl, prop)
`define CQS_ASSERT_MSG(lbl, prop, msg)

`endif

`endif

// ===== rtl/cqs_pkg.sv =====
// ---------------------------------------------------------------------------
// cqs_pkg
// Types, widths and codes shared by the ring-buffer queue with search.
// ---------------------------------------------------------------------------
package cqs_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CAP_W  = 7;
  localparam int KIND_W = 2;
  localparam int STAT_W = 2;
  localparam int VAL_W  = 32;
  localparam int SLOT_W = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_SEARCH = 2'd2
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    RES_HOLD,
    RES_OK,
    RES_FULL,
    RES_EMPTY,
    RES_NOT_FOUND,
    RES_REMOVED,
    RES_FOUND
  } res_sel_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic signed [VAL_W-1:0] operand_value;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic signed [VAL_W-1:0] removed_value;
    logic [SLOT_W-1:0] match_slot;
  } out_t;

  typedef struct packed {
    logic     load;
    logic     ins_wr;
    logic     rem_rd;
    logic     scan_start;
    logic     scan_step;
    logic     out_load;
    res_sel_e res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              full;
    logic              empty;
    logic              hit;
    logic              last_miss;
    logic              out_free;
  } dp_status_t;

endpackage

// ===== rtl/cqs_ctrl.sv =====
// ---------------------------------------------------------------------------
// cqs_ctrl
// Operation sequencer: dispatches insert, remove and search, posts results.
// ---------------------------------------------------------------------------
module cqs_ctrl
  import cqs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t st_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_REM_WAIT,
    S_SEARCH,
    S_POST
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_sel = RES_HOLD;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_POST;
        case (st_i.kind)
          KIND_INSERT: begin
            if (st_i.full) begin
              cmd_o.res_sel = RES_FULL;
            end else begin
              cmd_o.ins_wr  = 1'b1;
              cmd_o.res_sel = RES_OK;
            end
          end
          KIND_REMOVE: begin
            if (st_i.empty) begin
              cmd_o.res_sel = RES_EMPTY;
            end else begin
              cmd_o.rem_rd = 1'b1;
              state_d      = S_REM_WAIT;
            end
          end
          KIND_SEARCH: begin
            if (st_i.empty) begin
              cmd_o.res_sel = RES_EMPTY;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_SEARCH;
            end
          end
          default: begin
            cmd_o.res_sel = RES_OK;
          end
        endcase
      end
      S_REM_WAIT: begin
        cmd_o.res_sel = RES_REMOVED;
        state_d       = S_POST;
      end
      S_SEARCH: begin
        cmd_o.scan_step = 1'b1;
        if (st_i.hit) begin
          cmd_o.res_sel = RES_FOUND;
          state_d       = S_POST;
        end else if (st_i.last_miss) begin
          cmd_o.res_sel = RES_NOT_FOUND;
          state_d       = S_POST;
        end
      end
      S_POST: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/cqs_datapath.sv =====
// ---------------------------------------------------------------------------
// cqs_datapath
// Ring store, head/tail/count, search scan pipeline and result registers.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cqs_datapath
  import cqs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  in_t              in_data_i,
  input  logic             cfg_valid_i,
  input  logic [CAP_W-1:0] cfg_data_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output out_t             out_data_o,
  input  dp_cmd_t          cmd_i,
  output dp_status_t       st_o
);

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_q;
  logic [IDX_W-1:0]      rd_addr;

  logic [CAP_W-1:0]      cap_q;
  logic [CNT_W-1:0]      cap_use;
  logic [IDX_W-1:0]      head_q, tail_q;
  logic [CNT_W-1:0]      count_q;

  logic [KIND_W-1:0]     kind_q;
  logic [DATA_WIDTH-1:0] key_q;
  logic [63:0]           key_ext;

  logic [IDX_W-1:0]      scan_idx_q;
  logic [CNT_W-1:0]      scan_left_q;
  logic                  cmp_valid_q;
  logic                  cmp_last_q;
  logic [IDX_W-1:0]      cmp_idx_q;

  logic                  hit;
  logic [63:0]           rd_ext;
  logic [31:0]           slot_w;

  out_t                  res_q;
  out_t                  out_q;
  logic                  out_valid_q;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] cap);
    logic [31:0] n;
    n = 32'(idx) + 32'd1;
    if (n >= 32'(cap)) begin
      return '0;
    end
    return n[IDX_W-1:0];
  endfunction

  always_comb begin
    if (cap_q == '0) begin
      cap_use = CNT_W'(1);
    end else if (32'(cap_q) > 32'(DEPTH)) begin
      cap_use = CNT_W'(DEPTH);
    end else begin
      cap_use = CNT_W'(cap_q);
    end
  end

  assign key_ext = {{32{in_data_i.operand_value[VAL_W-1]}}, in_data_i.operand_value};
  assign rd_addr = cmd_i.scan_step ? scan_idx_q : head_q;
  assign hit     = cmp_valid_q && (rd_data_q == key_q);
  assign rd_ext  = 64'(rd_data_q);
  assign slot_w  = 32'(cmp_idx_q) + 32'd1;

  assign st_o.kind      = kind_q;
  assign st_o.full      = (count_q >= cap_use);
  assign st_o.empty     = (count_q == '0);
  assign st_o.hit       = hit;
  assign st_o.last_miss = cmp_valid_q && cmp_last_q && !hit;
  assign st_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ring store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_wr) begin
      mem_q[tail_q] <= key_q;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_W'(64);
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      cmp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (cmd_i.ins_wr) begin
        tail_q  <= next_slot(tail_q, cap_use);
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.rem_rd) begin
        head_q  <= next_slot(head_q, cap_use);
        count_q <= count_q - CNT_W'(1);
      end
      if (cmd_i.scan_start) begin
        cmp_valid_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        cmp_valid_q <= (scan_left_q != '0);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= in_data_i.kind;
      key_q  <= key_ext[DATA_WIDTH-1:0];
    end
    // issue one read per cycle, compare on the next
    if (cmd_i.scan_start) begin
      scan_idx_q  <= head_q;
      scan_left_q <= count_q;
    end else if (cmd_i.scan_step) begin
      cmp_idx_q   <= scan_idx_q;
      cmp_last_q  <= (scan_left_q == CNT_W'(1));
      scan_idx_q  <= next_slot(scan_idx_q, cap_use);
      if (scan_left_q != '0) begin
        scan_left_q <= scan_left_q - CNT_W'(1);
      end
    end
    case (cmd_i.res_sel)
      RES_OK:        res_q <= '{status: ST_OK, removed_value: '0, match_slot: '0};
      RES_FULL:      res_q <= '{status: ST_FULL, removed_value: '0, match_slot: '0};
      RES_EMPTY:     res_q <= '{status: ST_EMPTY, removed_value: '0, match_slot: '0};
      RES_NOT_FOUND: res_q <= '{status: ST_NOT_FOUND, removed_value: '0, match_slot: '0};
      RES_REMOVED:   res_q <= '{status: ST_OK, removed_value: rd_ext[VAL_W-1:0],
                                match_slot: '0};
      RES_FOUND:     res_q <= '{status: ST_OK, removed_value: '0,
                                match_slot: slot_w[SLOT_W-1:0]};
      default:       res_q <= res_q;
    endcase
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  `CQS_ASSERT_MSG(a_no_write_when_full, cmd_i.ins_wr |-> !st_o.full, "insert while full")
  `CQS_ASSERT_MSG(a_no_read_when_empty, cmd_i.rem_rd |-> !st_o.empty, "remove while empty")
  `CQS_ASSERT(a_no_result_overwrite, cmd_i.out_load |-> st_o.out_free)
  `CQS_ASSERT(a_remove_drops_count, cmd_i.rem_rd |=> count_q == $past(count_q) - CNT_W'(1))
  `CQS_ASSERT(a_count_bounded, count_q <= CNT_W'(DEPTH))

endmodule

// ===== rtl/circular_queue_with_search.sv =====
// ---------------------------------------------------------------------------
// circular_queue_with_search
// Ring-buffer queue of signed values with insert, remove and in-order search.
// ---------------------------------------------------------------------------
// Usage:
//   in channel  : one beat is one operation (insert, remove, search, no-op).
//   out channel : exactly one result beat per accepted operation, in order.
//   cfg channel : writes the capacity; write only while the queue is idle.
// Sequence, accept to out_valid_o:
//   insert, no-op, full or empty cases : execute, then post the result
//   remove                             : execute, read the store, then post
//   search                             : scan from the head up to the first
//                                        match or the last entry, then post
//   The search walks the ring through the single registered read port of
//   the store, one entry per cycle. One operation is in flight at a time;
//   the next beat is taken once the previous result sits in the output
//   register, even while the receiver has not taken it.
// Reset: queue empty, head and tail at slot zero, capacity 64, no result
//   pending. The store itself is not cleared.
// Receiver stall: the result beat holds in the output register; a further
//   operation runs but waits to post its result until that beat is taken.
// ---------------------------------------------------------------------------
module circular_queue_with_search
  import cqs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_t             out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CAP_W-1:0] cfg_data_i
);

  dp_cmd_t    cmd;
  dp_status_t st;

  assign cfg_ready_o = 1'b1;

  cqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  cqs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .st_o        (st)
  );

endmodule
